/* rtl/dotq_pkg.sv */
// Package for the deadline-ordered task queue: widths, codes and shared types.
// No dependencies.
package dotq_pkg;

   localparam int QueueDepthDefault = 16;
   localparam int KindCount         = 3;

   localparam int TimeWidth = 16;
   localparam int KindWidth = 2;
   localparam int TolWidth  = 15;
   localparam int ModeWidth = 2;
   localparam int CsrWidth  = 15;

   typedef enum logic {
      OP_INSERT   = 1'b0,
      OP_DISPATCH = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD      = 3'd1,
      ST_FULL     = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_LATE     = 3'd4,
      ST_NOT_IDLE = 3'd5
   } status_type;

   typedef enum logic {
      CSR_LATE_TOLERANCE = 1'b0,
      CSR_RUN_MODE       = 1'b1
   } csr_index_type;

   localparam logic [ModeWidth-1:0] ModeIdle = '0;

   // one queue slot as handed between neighbor cells
   typedef struct packed {
      logic                 occ;
      logic [TimeWidth-1:0] due;
      logic [KindWidth-1:0] kind;
   } slot_type;

   // command broadcast to every cell
   typedef struct packed {
      logic                 ins_en;
      logic                 pop_en;
      logic [TimeWidth-1:0] due;
      logic [KindWidth-1:0] kind;
   } cell_cmd_type;

endpackage

/* rtl/dotq_if.sv */
// Valid/ready channel interfaces for request and response transfers.
// Depends on dotq_pkg.
interface dotq_req_if;
   logic                             valid;
   logic                             ready;
   logic                             operation;
   logic [dotq_pkg::TimeWidth-1:0]   time_stamp;
   logic [dotq_pkg::KindWidth-1:0]   task_kind;
   logic                             has_handler;

   modport source (output valid, operation, time_stamp, task_kind, has_handler,
                   input ready);
   modport sink   (input valid, operation, time_stamp, task_kind, has_handler,
                   output ready);
endinterface

interface dotq_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [2:0]                            status;
   logic [dotq_pkg::KindWidth-1:0]        out_kind;
   logic [dotq_pkg::TimeWidth-1:0]        out_time;
   logic signed [dotq_pkg::TimeWidth-1:0] time_gap;
   logic                                  gap_valid;

   modport source (output valid, status, out_kind, out_time, time_gap, gap_valid,
                   input ready);
   modport sink   (input valid, status, out_kind, out_time, time_gap, gap_valid,
                   output ready);
endinterface

/* rtl/dotq_cell.sv */
// One slot of the sorted queue: holds an entry, shifts toward tail on insert
// and toward head on pop. Depends on dotq_pkg.
module dotq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  dotq_pkg::cell_cmd_type cmd,
   input  dotq_pkg::slot_type     prev_slot,
   input  logic                   prev_keep,
   input  dotq_pkg::slot_type     next_slot,
   output dotq_pkg::slot_type     slot,
   output logic                   keep
);
   import dotq_pkg::*;

   logic                 occ_ff, occ_in;
   logic [TimeWidth-1:0] due_ff, due_in;
   logic [KindWidth-1:0] kind_ff, kind_in;

   // entries at or before the new due time stay put
   assign keep = occ_ff && (due_ff <= cmd.due);

   always_comb begin
      occ_in  = occ_ff;
      due_in  = due_ff;
      kind_in = kind_ff;
      if (cmd.pop_en) begin
         occ_in  = next_slot.occ;
         due_in  = next_slot.due;
         kind_in = next_slot.kind;
      end else if (cmd.ins_en && !keep) begin
         if (prev_keep) begin
            occ_in  = 1'b1;
            due_in  = cmd.due;
            kind_in = cmd.kind;
         end else begin
            occ_in  = prev_slot.occ;
            due_in  = prev_slot.due;
            kind_in = prev_slot.kind;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
      due_ff  <= due_in;
      kind_ff <= kind_in;
   end

   assign slot.occ  = occ_ff;
   assign slot.due  = due_ff;
   assign slot.kind = kind_ff;

endmodule

/* rtl/deadline_ordered_task_queue.sv */
// Top level of the deadline-ordered task queue: cell chain, checks and result register.
// Depends on dotq_pkg, dotq_if and dotq_cell.
//
// Pending tasks sit in a row of QUEUE_DEPTH cells sorted by due time, head in
// cell 0; equal due times keep arrival order. Every cell compares its own due
// time with the request in parallel, so inserts and dispatches shift the row
// together: one request transfer per clock unless the response side stalls,
// with its response registered and presented the next cycle. A new request
// is taken while the previous response is being transferred. Configuration writes take
// effect at the next edge and are meant to happen while no response is outstanding.
module deadline_ordered_task_queue #(
   parameter int QUEUE_DEPTH = dotq_pkg::QueueDepthDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   dotq_req_if.sink                      req,
   dotq_rsp_if.source                    rsp,
   input  logic                          csr_write_en,
   input  logic                          csr_index,
   input  logic [dotq_pkg::CsrWidth-1:0] csr_wdata
);
   import dotq_pkg::*;

   slot_type     slots [QUEUE_DEPTH];
   logic         keeps [QUEUE_DEPTH];
   cell_cmd_type cmd;

   logic [TolWidth-1:0]  late_tol_ff;
   logic [ModeWidth-1:0] run_mode_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           status_ff, status_in;
   logic [KindWidth-1:0] out_kind_ff, out_kind_in;
   logic [TimeWidth-1:0] out_time_ff, out_time_in;
   logic [TimeWidth-1:0] gap_ff, gap_in;
   logic                 gap_valid_ff, gap_valid_in;

   logic                 accept;
   logic                 bad_req;
   logic                 full;
   logic [TimeWidth-1:0] late_gap;
   logic [TimeWidth-1:0] next_gap;
   logic                 too_late;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign bad_req  = ({1'b0, req.task_kind} >= 3'(KindCount)) || !req.has_handler;
   assign full     = slots[QUEUE_DEPTH-1].occ;
   assign late_gap = req.time_stamp - slots[0].due;
   assign next_gap = req.time_stamp - slots[1].due;
   assign too_late = $signed(late_gap) > $signed({1'b0, late_tol_ff});

   always_comb begin
      cmd.ins_en   = 1'b0;
      cmd.pop_en   = 1'b0;
      cmd.due      = req.time_stamp;
      cmd.kind     = req.task_kind;
      status_in    = ST_OK;
      out_kind_in  = '0;
      out_time_in  = '0;
      gap_in       = '0;
      gap_valid_in = 1'b0;
      if (op_type'(req.operation) == OP_INSERT) begin
         if (bad_req) begin
            status_in = ST_BAD;
         end else if (full) begin
            status_in = ST_FULL;
         end else begin
            cmd.ins_en = accept;
         end
      end else begin
         if (!slots[0].occ) begin
            status_in = ST_EMPTY;
         end else if (too_late) begin
            status_in    = ST_LATE;
            gap_in       = late_gap;
            gap_valid_in = 1'b1;
         end else if (run_mode_ff != ModeIdle) begin
            status_in = ST_NOT_IDLE;
         end else begin
            cmd.pop_en   = accept;
            out_kind_in  = slots[0].kind;
            out_time_in  = slots[0].due;
            gap_valid_in = slots[1].occ;
            gap_in       = slots[1].occ ? next_gap : '0;
         end
      end
      rsp_valid_in = accept || (rsp_valid_ff && !rsp.ready);
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      slot_type prev_slot;
      slot_type next_slot;
      logic     prev_keep;
      if (i == 0) begin : g_head
         assign prev_slot = '0;
         assign prev_keep = 1'b1;
      end else begin : g_body
         assign prev_slot = slots[i-1];
         assign prev_keep = keeps[i-1];
      end
      if (i == QUEUE_DEPTH-1) begin : g_tail
         assign next_slot = '0;
      end else begin : g_inner
         assign next_slot = slots[i+1];
      end
      dotq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .prev_slot (prev_slot),
         .prev_keep (prev_keep),
         .next_slot (next_slot),
         .slot      (slots[i]),
         .keep      (keeps[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         late_tol_ff <= TolWidth'(5);
         run_mode_ff <= ModeIdle;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_LATE_TOLERANCE: late_tol_ff <= csr_wdata[TolWidth-1:0];
            CSR_RUN_MODE:       run_mode_ff <= csr_wdata[ModeWidth-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         status_ff    <= status_in;
         out_kind_ff  <= out_kind_in;
         out_time_ff  <= out_time_in;
         gap_ff       <= gap_in;
         gap_valid_ff <= gap_valid_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = status_ff;
   assign rsp.out_kind  = out_kind_ff;
   assign rsp.out_time  = out_time_ff;
   assign rsp.time_gap  = $signed(gap_ff);
   assign rsp.gap_valid = gap_valid_ff;

endmodule

/* rtl/dotq_checker.sv */
// Port-level checks for deadline_ordered_task_queue, attached by bind.
// Depends on dotq_pkg.
module dotq_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [2:0]                    rsp_status,
   input logic [dotq_pkg::TimeWidth-1:0] rsp_time_gap,
   input logic                          rsp_gap_valid
);
   import dotq_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request gave no response");

   a_gap_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_gap_valid |-> rsp_status == ST_OK || rsp_status == ST_LATE)
      else $error("gap reported with wrong status");

   a_late_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_LATE |->
         rsp_gap_valid && !rsp_time_gap[TimeWidth-1] && rsp_time_gap != '0)
      else $error("late status without positive lateness");

endmodule

bind deadline_ordered_task_queue dotq_checker u_dotq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_status    (rsp.status),
   .rsp_time_gap  (rsp.time_gap),
   .rsp_gap_valid (rsp.gap_valid)
);
